// ===== sv/sbt_pkg.sv =====
// Shared types and constants for the subresource state barrier tracker.
// Holds command and status codes, field widths and the table access struct.
// No dependencies.
package sbt_pkg;

    // Field widths fixed by the interface.
    localparam int CMD_W    = 2;
    localparam int STATE_W  = 32;
    localparam int IDX_W    = 6;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    // Request commands.
    localparam logic [CMD_W-1:0] CMD_SET_ONE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_ALL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FILL    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SUBRES = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LOCKED    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SUBRES_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKED       = 1'd1;

    // Access to the state table: write enable, write address and data, read address.
    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   wa;
        logic [STATE_W-1:0] wd;
        logic [IDX_W-1:0]   ra;
    } t_tbl_req;

endpackage

// ===== sv/sbt_table.sv =====
// State table of the barrier tracker: one synchronous memory word per entry.
// Entries never written since reset read as zero through per-entry valid bits.
// Depends on sbt_pkg.
module sbt_table #(
    parameter int MAX_SUBRES = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sbt_pkg::t_tbl_req       i_req,
    output logic [sbt_pkg::STATE_W-1:0] o_rd_data
);
    import sbt_pkg::*;

    localparam int AW = (MAX_SUBRES > 1) ? $clog2(MAX_SUBRES) : 1;

    logic [STATE_W-1:0]    r_mem [MAX_SUBRES];
    logic [MAX_SUBRES-1:0] r_vld;
    logic [STATE_W-1:0]    r_rd_data;
    logic                  r_rd_vld;
    logic [AW-1:0]         wa;
    logic [AW-1:0]         ra;

    assign wa = i_req.wa[AW-1:0];
    assign ra = i_req.ra[AW-1:0];

    // Memory array with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[wa] <= i_req.wd;
        end
        r_rd_data <= r_mem[ra];
    end

    // Valid bits mark entries written since reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[wa] <= 1'b1;
            end
            r_rd_vld <= r_vld[ra];
        end
    end

    // An entry that was never written reads as the reset state.
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== sv/subresource_state_barrier_tracker.sv =====
// A fill, an unused command or a refused request answers the cycle after start,
// except that a fill first writes one entry per cycle and answers after its last entry.
// A set walking N entries (N = 1 for set-one) shows its final result after
// N reads, then one compare stage, the flush step and the output register.
// One request at a time; busy covers the walk, flush and fill, and a new start is
// taken only once busy is low. Sync active-low reset: count 1, unlocked, table zero.
module subresource_state_barrier_tracker #(
    parameter int MAX_SUBRES = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [sbt_pkg::CMD_W-1:0]         i_cmd,
    input  logic [sbt_pkg::STATE_W-1:0]       i_target_state,
    input  logic [sbt_pkg::IDX_W-1:0]         i_subres_index,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sbt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sbt_pkg::COUNT_W-1:0]       i_cfg_data,
    output logic                              o_res_valid,
    output logic [sbt_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_has_barrier,
    output logic [sbt_pkg::IDX_W-1:0]         o_barrier_index,
    output logic [sbt_pkg::STATE_W-1:0]       o_state_before,
    output logic [sbt_pkg::STATE_W-1:0]       o_state_after,
    output logic                              o_last
);
    import sbt_pkg::*;

    localparam int AW = (MAX_SUBRES > 1) ? $clog2(MAX_SUBRES) : 1;
    localparam logic [AW-1:0]      LAST_ENTRY = AW'(MAX_SUBRES - 1);
    localparam logic [COUNT_W-1:0] MAX_COUNT  = COUNT_W'(MAX_SUBRES);

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;
    localparam logic [1:0] S_FILL  = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [COUNT_W-1:0]  r_cfg_count;
    logic                r_cfg_locked;
    logic [AW-1:0]       r_ptr, n_ptr;
    logic [AW-1:0]       r_end, n_end;
    logic                r_issue, n_issue;
    logic                r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]       r_cmp_idx, n_cmp_idx;
    logic [STATE_W-1:0]  r_target, n_target;
    logic                r_pend, n_pend;
    logic [AW-1:0]       r_pend_idx, n_pend_idx;
    logic [STATE_W-1:0]  r_pend_old, n_pend_old;

    logic                r_out_vld, n_out_vld;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic                r_out_hb, n_out_hb;
    logic [IDX_W-1:0]    r_out_idx, n_out_idx;
    logic [STATE_W-1:0]  r_out_before, n_out_before;
    logic [STATE_W-1:0]  r_out_after, n_out_after;
    logic                r_out_last, n_out_last;

    t_tbl_req            tbl_req;
    logic [STATE_W-1:0]  rd_data;
    logic [COUNT_W-1:0]  eff_count;
    logic                accept;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign eff_count   = (r_cfg_count > MAX_COUNT) ? MAX_COUNT : r_cfg_count;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count  <= COUNT_W'(1);
            r_cfg_locked <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SUBRES_COUNT: r_cfg_count  <= i_cfg_data;
                CFG_LOCKED:       r_cfg_locked <= i_cfg_data[0];
                default:          r_cfg_count  <= r_cfg_count;
            endcase
        end
    end

    // State table.
    sbt_table #(
        .MAX_SUBRES(MAX_SUBRES)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (tbl_req),
        .o_rd_data(rd_data)
    );

    // Sequencer: decode at start, then a pipelined read-compare-write walk.
    // The read of entry k overlaps the write-back of entry k-1, so the two
    // ports touch different entries except at the final entry, whose re-read is unused.
    always_comb begin
        n_state      = r_state;
        n_ptr        = r_ptr;
        n_end        = r_end;
        n_issue      = r_issue;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_target     = r_target;
        n_pend       = r_pend;
        n_pend_idx   = r_pend_idx;
        n_pend_old   = r_pend_old;
        n_out_vld    = 1'b0;
        n_out_status = ST_OK;
        n_out_hb     = 1'b0;
        n_out_idx    = '0;
        n_out_before = '0;
        n_out_after  = '0;
        n_out_last   = 1'b1;
        tbl_req.we   = 1'b0;
        tbl_req.wa   = IDX_W'(r_cmp_idx);
        tbl_req.wd   = r_target;
        tbl_req.ra   = IDX_W'(r_ptr);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_target = i_target_state;
                    n_pend   = 1'b0;
                    n_ptr    = '0;
                    if (i_cmd == CMD_FILL) begin
                        n_state = S_FILL;
                    end else if (i_cmd == CMD_NOP) begin
                        n_out_vld = 1'b1;
                    end else if (eff_count == '0) begin
                        n_out_vld    = 1'b1;
                        n_out_status = ST_NO_SUBRES;
                    end else if (r_cfg_locked) begin
                        n_out_vld    = 1'b1;
                        n_out_status = ST_LOCKED;
                    end else if (i_cmd == CMD_SET_ONE) begin
                        if ({1'b0, i_subres_index} >= eff_count) begin
                            n_out_vld    = 1'b1;
                            n_out_status = ST_BAD_INDEX;
                        end else begin
                            n_ptr   = AW'(i_subres_index);
                            n_end   = AW'(i_subres_index);
                            n_issue = 1'b1;
                            n_state = S_WALK;
                        end
                    end else begin
                        n_end   = AW'(eff_count - COUNT_W'(1));
                        n_issue = 1'b1;
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // Issue the next read.
                if (r_issue) begin
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_ptr;
                    if (r_ptr == r_end) begin
                        n_issue = 1'b0;
                    end else begin
                        n_ptr = r_ptr + AW'(1);
                    end
                end
                // Compare returned data, write back and queue a record.
                // A record is held back until the next write-back or the flush so that the final one can carry last.
                if (r_cmp_vld) begin
                    if (rd_data != r_target) begin
                        tbl_req.we = 1'b1;
                        n_pend     = 1'b1;
                        n_pend_idx = r_cmp_idx;
                        n_pend_old = rd_data;
                        if (r_pend) begin
                            n_out_vld    = 1'b1;
                            n_out_hb     = 1'b1;
                            n_out_idx    = IDX_W'(r_pend_idx);
                            n_out_before = r_pend_old;
                            n_out_after  = r_target;
                            n_out_last   = 1'b0;
                        end
                    end
                    if (r_cmp_idx == r_end) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                // Final result: the held record, or a no-transition result.
                n_out_vld = 1'b1;
                if (r_pend) begin
                    n_out_hb     = 1'b1;
                    n_out_idx    = IDX_W'(r_pend_idx);
                    n_out_before = r_pend_old;
                    n_out_after  = r_target;
                end
                n_pend  = 1'b0;
                n_state = S_IDLE;
            end
            S_FILL: begin
                // Write the target into every entry, one per cycle.
                tbl_req.we = 1'b1;
                tbl_req.wa = IDX_W'(r_ptr);
                if (r_ptr == LAST_ENTRY) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issue   <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issue   <= n_issue;
            r_cmp_vld <= n_cmp_vld;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_end        <= n_end;
        r_cmp_idx    <= n_cmp_idx;
        r_target     <= n_target;
        r_pend_idx   <= n_pend_idx;
        r_pend_old   <= n_pend_old;
        r_out_status <= n_out_status;
        r_out_hb     <= n_out_hb;
        r_out_idx    <= n_out_idx;
        r_out_before <= n_out_before;
        r_out_after  <= n_out_after;
        r_out_last   <= n_out_last;
    end

    // Result ports.
    assign o_res_valid     = r_out_vld;
    assign o_status        = r_out_status;
    assign o_has_barrier   = r_out_hb;
    assign o_barrier_index = r_out_idx;
    assign o_state_before  = r_out_before;
    assign o_state_after   = r_out_after;
    assign o_last          = r_out_last;

`ifndef SYNTHESIS
    // An accepted request either starts a walk or fill, or answers on the next cycle.
    a_start_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_res_valid))
        else $error("accepted request produced neither a walk nor a result");

    // Intermediate records only come out of a table walk.
    a_mid_record_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_last) |-> (r_state == S_WALK || r_state == S_FLUSH))
        else $error("non-final result outside a table walk");

    // The table is written only during a walk or a fill.
    a_write_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_req.we |-> (r_state == S_WALK || r_state == S_FILL))
        else $error("table write while idle");

    // No compare data is pending once the sequencer is idle.
    a_idle_no_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (!r_cmp_vld && !r_pend))
        else $error("compare stage active while idle");
`endif

endmodule
